>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the chunked body decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hcbd assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

>>> hdl/hcbd_pkg.sv
// Types and phase codes of the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    // Parser phase codes
    typedef logic [2:0] t_phase;
    localparam t_phase PH_WS        = 3'd0;
    localparam t_phase PH_DIGITS    = 3'd1;
    localparam t_phase PH_SKIP_SIZE = 3'd2;
    localparam t_phase PH_DATA      = 3'd3;
    localparam t_phase PH_SKIP_DATA = 3'd4;
    localparam t_phase PH_FINISHED  = 3'd5;
    localparam t_phase PH_FAILED    = 3'd6;

    localparam int TOTAL_BITS = 32;

    // Control state of the parser (size register travels separately)
    typedef struct packed {
        t_phase                  phase;
        logic                    digit_seen;
        logic [1:0]              skip_left;
        logic                    done;
        logic                    error;
        logic [TOTAL_BITS-1:0]   total;
    } t_ctl;

    // One result word
    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    out_valid;
        logic                    out_done;
        logic                    out_error;
        logic [TOTAL_BITS-1:0]   out_total;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/hcbd_if.sv
// Valid/ready channel interfaces for the body byte input and the result output.
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hcbd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_done;
    logic        out_error;
    logic [31:0] out_total;

    modport source (output valid, output out_byte, output out_valid, output out_done,
                    output out_error, output out_total, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_done,
                    input out_error, input out_total, output ready);
endinterface

`default_nettype wire

>>> hdl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input register, parser state, result register.
//
// Usage: body bytes enter on i_in (in_byte, in_last), one word per byte; in_last
// marks the last byte of a body. For every input word exactly one result word
// leaves on o_out: out_valid/out_byte carry a payload byte when the input byte
// was chunk data, out_done rises once the zero-size chunk is parsed, out_error
// is a sticky flag for bad size digits, size overflow or a truncated body, and
// out_total counts payload bytes of the current body (saturating).
// Path: a word taken on i_in passes the input register, then the parser update
// into the result register, before it is offered on o_out.
// Throughput: one word per cycle unless stalled; the parser state updates once per word.
// Stall: when the receiver holds ready low, the result register holds its word,
// the input register fills, and then i_in.ready drops; nothing is lost.
// Reset (synchronous, active low) empties both registers and returns the parser
// to whitespace skipping before the first size; after a word with in_last the
// parser state returns to that same start state.
`default_nettype none
`include "assert_macros.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcbd_in_if.sink           i_in,
    hcbd_out_if.source        o_out
);
    import hcbd_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    t_ctl                 r_ctl;
    t_ctl                 n_ctl;
    logic [SIZE_BITS-1:0] r_chunk;
    logic [SIZE_BITS-1:0] n_chunk;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;
    logic                 adv;

    // Word moves from input register to result register
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || adv);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_chunk (r_chunk),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_ctl   (n_ctl),
        .o_chunk (n_chunk),
        .o_res   (n_out)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '{phase: PH_WS, digit_seen: 1'b0, skip_left: 2'd0,
                         done: 1'b0, error: 1'b0, total: '0};
            r_chunk <= '0;
        end else if (adv) begin
            r_ctl   <= n_ctl;
            r_chunk <= n_chunk;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out.out_byte;
    assign o_out.out_valid = r_out.out_valid;
    assign o_out.out_done  = r_out.out_done;
    assign o_out.out_error = r_out.out_error;
    assign o_out.out_total = r_out.out_total;

    // Checks
    `HCBD_ASSERT_ALWAYS(a_err_phase, i_clk, i_rst_n, r_ctl.error == (r_ctl.phase == PH_FAILED))
    `HCBD_ASSERT_ALWAYS(a_done_phase, i_clk, i_rst_n, r_ctl.done == (r_ctl.phase == PH_FINISHED))
    `HCBD_ASSERT_ALWAYS(a_data_left, i_clk, i_rst_n, (r_ctl.phase != PH_DATA) || (r_chunk != '0))
    `HCBD_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, adv && r_in_last, (r_ctl.phase == PH_WS) && (r_ctl.total == '0) && (r_chunk == '0))

endmodule

`default_nettype wire

>>> hdl/hcbd_step.sv
// Next-state and result logic of the chunked body parser for one byte.
`default_nettype none

module hcbd_step #(
    parameter int SIZE_BITS = 32
) (
    input  hcbd_pkg::t_ctl          i_ctl,
    input  logic [SIZE_BITS-1:0]    i_chunk,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output hcbd_pkg::t_ctl          o_ctl,
    output logic [SIZE_BITS-1:0]    o_chunk,
    output hcbd_pkg::t_result       o_res
);
    import hcbd_pkg::*;

    logic                 is_hex;
    logic [3:0]           hex_val;
    logic                 is_ws;
    logic                 size_full;
    t_ctl                 nc;
    logic [SIZE_BITS-1:0] nk;
    logic [1:0]           sl_dec;
    logic [SIZE_BITS-1:0] chunk_dec;

    // Hex digit decode
    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= "0" && i_byte <= "9") begin
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= "a" && i_byte <= "f") begin
            hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte >= "A" && i_byte <= "F") begin
            hex_val = 4'(i_byte - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Space, tab, LF, VT, FF, CR
    assign is_ws = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0d);

    // Another digit would overflow once the top nibble is in use
    assign size_full = |i_chunk[SIZE_BITS-1 -: 4];

    assign sl_dec    = i_ctl.skip_left - {1'b0, |i_ctl.skip_left};
    assign chunk_dec = i_chunk - {{(SIZE_BITS-1){1'b0}}, |i_chunk};

    always_comb begin
        nc    = i_ctl;
        nk    = i_chunk;
        o_res = '0;

        // Per-phase update
        unique case (i_ctl.phase)
            PH_WS, PH_DIGITS: begin
                if (is_hex) begin
                    if (size_full) begin
                        nc.error = 1'b1;
                        nc.phase = PH_FAILED;
                    end else begin
                        nk            = {i_chunk[SIZE_BITS-5:0], hex_val};
                        nc.digit_seen = 1'b1;
                        nc.phase      = PH_DIGITS;
                    end
                end else if (i_ctl.phase == PH_WS) begin
                    if (!is_ws) begin
                        nc.error = 1'b1;
                        nc.phase = PH_FAILED;
                    end
                end else if (i_chunk == '0) begin
                    nc.done  = 1'b1;
                    nc.phase = PH_FINISHED;
                end else begin
                    nc.skip_left = 2'd1;
                    nc.phase     = PH_SKIP_SIZE;
                end
            end
            PH_SKIP_SIZE: begin
                nc.skip_left = sl_dec;
                if (sl_dec == 2'd0) begin
                    nc.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_res.out_byte  = i_byte;
                o_res.out_valid = 1'b1;
                if (~&i_ctl.total) begin
                    nc.total = i_ctl.total + 1'b1;
                end
                nk = chunk_dec;
                if (chunk_dec == '0) begin
                    nc.skip_left = 2'd2;
                    nc.phase     = PH_SKIP_DATA;
                end
            end
            PH_SKIP_DATA: begin
                nc.skip_left = sl_dec;
                if (sl_dec == 2'd0) begin
                    nc.digit_seen = 1'b0;
                    nk            = '0;
                    nc.phase      = PH_WS;
                end
            end
            default: begin
            end
        endcase

        // End of body: a zero size running to the end completes, else truncated
        if (i_last && !nc.done && !nc.error) begin
            if (nc.phase == PH_DIGITS && nc.digit_seen && nk == '0) begin
                nc.done  = 1'b1;
                nc.phase = PH_FINISHED;
            end else begin
                nc.error = 1'b1;
                nc.phase = PH_FAILED;
            end
        end

        o_res.out_done  = nc.done;
        o_res.out_error = nc.error;
        o_res.out_total = nc.total;

        // Start over for the next body
        if (i_last) begin
            nc       = '0;
            nc.phase = PH_WS;
            nk       = '0;
        end
    end

    assign o_ctl   = nc;
    assign o_chunk = nk;

endmodule

`default_nettype wire
